### src/sfd_pkg.sv
`timescale 1ns / 1ps

package sfd_pkg;

    // Byte position within a frame; header restarts at POS_FIRST.
    localparam logic [3:0] POS_FIRST = 4'd1;
    localparam logic [3:0] POS_LAST  = 4'd11;
    localparam logic [3:0] POS_IDLE  = 4'd12;
    localparam int STORE_DEPTH = 10;
    localparam int STORE_IDX_W = 4;

    localparam int CH_W = 11;

    // Configuration register indexes
    localparam int CFG_ADDR_W = 2;
    localparam logic [CFG_ADDR_W-1:0] CFG_SW_HIGH = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SW_MID  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_SW_LOW  = 2'd2;

    localparam logic [CH_W-1:0] SW_HIGH_RST = 11'd1200;
    localparam logic [CH_W-1:0] SW_MID_RST  = 11'd800;
    localparam logic [CH_W-1:0] SW_LOW_RST  = 11'd100;

    // Switch position codes
    localparam logic signed [1:0] SW_POS  = 2'sb01;
    localparam logic signed [1:0] SW_ZERO = 2'sb00;
    localparam logic signed [1:0] SW_NEG  = 2'sb11;
    localparam logic signed [1:0] SW_BAD  = 2'sb10;

    // Angle maps: Q24 coefficients, result with ANGLE_FRAC_BITS fraction bits
    localparam int ANGLE_FRAC_BITS = 8;
    localparam int COEF_FRAC = 24;
    localparam int ANGLE_SHIFT = COEF_FRAC - ANGLE_FRAC_BITS;
    localparam int ANGLE_W = 15;
    localparam int DIFF_W = 13;
    localparam int COEF_W = 22;
    localparam int PROD_W = DIFF_W + COEF_W;
    localparam int Q_W = PROD_W + 1;

    localparam logic signed [COEF_W-1:0] ROLL_HI_COEF  = 22'sd924082;
    localparam logic signed [COEF_W-1:0] ROLL_LO_COEF  = 22'sd918462;
    localparam logic signed [COEF_W-1:0] PITCH_LO_COEF = 22'sd1003965;
    localparam logic signed [COEF_W-1:0] PITCH_HI_COEF = 22'sd851158;

    localparam logic [CH_W-1:0] ROLL_KNEE  = 11'd994;
    localparam logic [CH_W-1:0] PITCH_KNEE = 11'd924;
    localparam logic signed [DIFF_W-1:0] RAW_TOP    = 13'sd1811;
    localparam logic signed [DIFF_W-1:0] ROLL_FLOOR = 13'sd172;
    localparam logic signed [DIFF_W-1:0] PITCH_MID  = 13'sd924;

    localparam logic signed [Q_W-1:0] ANGLE_45_Q = 36'sd754974720;
    localparam logic signed [Q_W-1:0] ANGLE_RND =
        {{(Q_W-1){1'b0}}, 1'b1} << (ANGLE_SHIFT - 1);
    localparam logic signed [Q_W-1:0] ANGLE_MAX = 36'sd16383;
    localparam logic signed [Q_W-1:0] ANGLE_MIN = -36'sd16384;

    typedef struct packed {
        logic [CH_W-1:0] ch1;
        logic [CH_W-1:0] ch2;
        logic [CH_W-1:0] ch3;
        logic [CH_W-1:0] ch5;
        logic [CH_W-1:0] ch6;
        logic [CH_W-1:0] ch7;
        logic [CH_W-1:0] ch8;
    } sfd_chan_t;

    typedef struct packed {
        logic [CH_W-1:0] high;
        logic [CH_W-1:0] mid;
        logic [CH_W-1:0] low;
    } sfd_thresh_t;

endpackage

### src/sfd_frame_asm.sv
`timescale 1ns / 1ps

module sfd_frame_asm (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic                frame_start,
    input  logic [7:0]          rx_byte,
    input  logic                advance,
    output logic                s1_valid,
    output sfd_pkg::sfd_chan_t  s1_chan
);

    logic [3:0] pos_reg;
    logic [3:0] pos_next;
    logic [7:0] store_reg [sfd_pkg::STORE_DEPTH];
    logic [sfd_pkg::STORE_IDX_W-1:0] store_idx;
    logic store_we;
    logic in_frame;
    logic frame_done;
    logic s1_valid_reg;
    logic s1_valid_next;
    sfd_pkg::sfd_chan_t chan_reg;
    sfd_pkg::sfd_chan_t chan_next;

    always_comb
    begin
        in_frame   = (pos_reg >= sfd_pkg::POS_FIRST) && (pos_reg <= sfd_pkg::POS_LAST);
        pos_next   = pos_reg;
        store_we   = 1'b0;
        frame_done = 1'b0;
        store_idx  = pos_reg - sfd_pkg::POS_FIRST;
        if (accept)
        begin
            if (frame_start)
            begin
                pos_next = sfd_pkg::POS_FIRST;
            end
            else if (in_frame)
            begin
                pos_next   = pos_reg + 4'd1;
                store_we   = (pos_reg != sfd_pkg::POS_LAST);
                frame_done = (pos_reg == sfd_pkg::POS_LAST);
            end
        end
    end

    // 11-bit channels packed LSB first from byte 1; byte 11 is the live word
    always_comb
    begin
        chan_next.ch1 = {store_reg[1][2:0], store_reg[0]};
        chan_next.ch2 = {store_reg[2][5:0], store_reg[1][7:3]};
        chan_next.ch3 = {store_reg[4][0], store_reg[3], store_reg[2][7:6]};
        chan_next.ch5 = {store_reg[6][6:0], store_reg[5][7:4]};
        chan_next.ch6 = {store_reg[8][1:0], store_reg[7], store_reg[6][7]};
        chan_next.ch7 = {store_reg[9][4:0], store_reg[8][7:2]};
        chan_next.ch8 = {rx_byte, store_reg[9][7:5]};
    end

    assign s1_valid_next = advance ? frame_done : s1_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= sfd_pkg::POS_IDLE;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg      <= pos_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_reg[store_idx] <= rx_byte;
        end
        if (frame_done)
        begin
            chan_reg <= chan_next;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1_chan  = chan_reg;

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= sfd_pkg::POS_IDLE)
        else $error("byte position out of range");

    a_start_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        accept && frame_start |=> pos_reg == sfd_pkg::POS_FIRST)
        else $error("header did not restart frame");

    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(s1_valid_reg) |->
            $past(accept && !frame_start && pos_reg == sfd_pkg::POS_LAST))
        else $error("frame result without last byte");

endmodule

### src/sfd_chan_conv.sv
`timescale 1ns / 1ps

module sfd_chan_conv (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         advance,
    input  logic                         s1_valid,
    input  sfd_pkg::sfd_chan_t           s1_chan,
    input  sfd_pkg::sfd_thresh_t         thresh,
    output logic                         out_valid,
    output logic [sfd_pkg::CH_W-1:0]     throttle,
    output logic signed [sfd_pkg::ANGLE_W-1:0] roll_deg,
    output logic signed [sfd_pkg::ANGLE_W-1:0] pitch_deg,
    output logic signed [1:0]            switch_a,
    output logic signed [1:0]            switch_b,
    output logic signed [1:0]            switch_c,
    output logic [sfd_pkg::CH_W-1:0]     aux_level
);

    function automatic logic signed [1:0] quantize(
        input logic [sfd_pkg::CH_W-1:0] raw,
        input logic signed [1:0]        held,
        input sfd_pkg::sfd_thresh_t     th
    );
        logic signed [1:0] pos;
        begin
            if (raw > th.high)
                pos = sfd_pkg::SW_POS;
            else if (raw > th.mid)
                pos = sfd_pkg::SW_ZERO;
            else if (raw > th.low)
                pos = sfd_pkg::SW_NEG;
            else
                pos = held;
            return pos;
        end
    endfunction

    // Round half up to ANGLE_FRAC_BITS, then clamp to the output range
    function automatic logic signed [sfd_pkg::ANGLE_W-1:0] to_angle(
        input logic signed [sfd_pkg::Q_W-1:0] q
    );
        logic signed [sfd_pkg::Q_W-1:0] v;
        begin
            v = (q + sfd_pkg::ANGLE_RND) >>> sfd_pkg::ANGLE_SHIFT;
            if (v > sfd_pkg::ANGLE_MAX)
                v = sfd_pkg::ANGLE_MAX;
            else if (v < sfd_pkg::ANGLE_MIN)
                v = sfd_pkg::ANGLE_MIN;
            return v[sfd_pkg::ANGLE_W-1:0];
        end
    endfunction

    logic signed [sfd_pkg::DIFF_W-1:0] roll_raw;
    logic signed [sfd_pkg::DIFF_W-1:0] pitch_raw;
    logic signed [sfd_pkg::DIFF_W-1:0] roll_diff;
    logic signed [sfd_pkg::DIFF_W-1:0] pitch_diff;
    logic signed [sfd_pkg::COEF_W-1:0] roll_coef;
    logic signed [sfd_pkg::COEF_W-1:0] pitch_coef;
    logic signed [sfd_pkg::Q_W-1:0]    roll_base_next;
    logic signed [sfd_pkg::Q_W-1:0]    pitch_base_next;
    logic signed [sfd_pkg::PROD_W-1:0] roll_prod_next;
    logic signed [sfd_pkg::PROD_W-1:0] pitch_prod_next;

    logic signed [sfd_pkg::Q_W-1:0]    roll_base_reg;
    logic signed [sfd_pkg::Q_W-1:0]    pitch_base_reg;
    logic signed [sfd_pkg::PROD_W-1:0] roll_prod_reg;
    logic signed [sfd_pkg::PROD_W-1:0] pitch_prod_reg;
    logic [sfd_pkg::CH_W-1:0]          s2_throttle_reg;
    logic [sfd_pkg::CH_W-1:0]          s2_aux_reg;
    logic signed [1:0]                 sw_a_next;
    logic signed [1:0]                 sw_b_next;
    logic signed [1:0]                 sw_c_next;
    logic signed [1:0]                 s2_sw_a_reg;
    logic signed [1:0]                 s2_sw_b_reg;
    logic signed [1:0]                 s2_sw_c_reg;
    logic signed [1:0]                 held_a_reg;
    logic signed [1:0]                 held_b_reg;
    logic signed [1:0]                 held_c_reg;
    logic                              s1_take;
    logic                              s2_valid_reg;
    logic                              s2_valid_next;
    logic                              out_valid_reg;
    logic                              out_valid_next;

    logic [sfd_pkg::CH_W-1:0]              out_throttle_reg;
    logic [sfd_pkg::CH_W-1:0]              out_aux_reg;
    logic signed [sfd_pkg::ANGLE_W-1:0]    out_roll_reg;
    logic signed [sfd_pkg::ANGLE_W-1:0]    out_pitch_reg;
    logic signed [1:0]                     out_sw_a_reg;
    logic signed [1:0]                     out_sw_b_reg;
    logic signed [1:0]                     out_sw_c_reg;

    assign s1_take = s1_valid && advance;

    // Stage 2: pick the segment of each map, multiply, and quantize the switches
    always_comb
    begin
        roll_raw  = {2'b00, s1_chan.ch2};
        pitch_raw = {2'b00, s1_chan.ch3};
        if (s1_chan.ch2 >= sfd_pkg::ROLL_KNEE)
        begin
            roll_diff      = roll_raw - sfd_pkg::RAW_TOP;
            roll_coef      = sfd_pkg::ROLL_HI_COEF;
            roll_base_next = sfd_pkg::ANGLE_45_Q;
        end
        else
        begin
            roll_diff      = roll_raw - sfd_pkg::ROLL_FLOOR;
            roll_coef      = sfd_pkg::ROLL_LO_COEF;
            roll_base_next = -sfd_pkg::ANGLE_45_Q;
        end
        if (s1_chan.ch3 <= sfd_pkg::PITCH_KNEE)
        begin
            pitch_diff      = pitch_raw - sfd_pkg::PITCH_MID;
            pitch_coef      = sfd_pkg::PITCH_LO_COEF;
            pitch_base_next = '0;
        end
        else
        begin
            pitch_diff      = pitch_raw - sfd_pkg::RAW_TOP;
            pitch_coef      = sfd_pkg::PITCH_HI_COEF;
            pitch_base_next = sfd_pkg::ANGLE_45_Q;
        end
        roll_prod_next  = roll_diff * roll_coef;
        pitch_prod_next = pitch_diff * pitch_coef;
        sw_a_next = quantize(s1_chan.ch5, held_a_reg, thresh);
        sw_b_next = quantize(s1_chan.ch6, held_b_reg, thresh);
        sw_c_next = quantize(s1_chan.ch8, held_c_reg, thresh);
    end

    assign s2_valid_next  = advance ? s1_valid : s2_valid_reg;
    assign out_valid_next = advance ? s2_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            held_a_reg    <= sfd_pkg::SW_ZERO;
            held_b_reg    <= sfd_pkg::SW_ZERO;
            held_c_reg    <= sfd_pkg::SW_ZERO;
        end
        else
        begin
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_take)
            begin
                held_a_reg <= sw_a_next;
                held_b_reg <= sw_b_next;
                held_c_reg <= sw_c_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_take)
        begin
            roll_prod_reg   <= roll_prod_next;
            pitch_prod_reg  <= pitch_prod_next;
            roll_base_reg   <= roll_base_next;
            pitch_base_reg  <= pitch_base_next;
            s2_throttle_reg <= s1_chan.ch1;
            s2_aux_reg      <= s1_chan.ch7;
            s2_sw_a_reg     <= sw_a_next;
            s2_sw_b_reg     <= sw_b_next;
            s2_sw_c_reg     <= sw_c_next;
        end
        // Stage 3: add segment base, round, clamp
        if (advance && s2_valid_reg)
        begin
            out_roll_reg     <= to_angle(roll_base_reg + sfd_pkg::Q_W'(roll_prod_reg));
            out_pitch_reg    <= to_angle(pitch_base_reg + sfd_pkg::Q_W'(pitch_prod_reg));
            out_throttle_reg <= s2_throttle_reg;
            out_aux_reg      <= s2_aux_reg;
            out_sw_a_reg     <= s2_sw_a_reg;
            out_sw_b_reg     <= s2_sw_b_reg;
            out_sw_c_reg     <= s2_sw_c_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign throttle  = out_throttle_reg;
    assign roll_deg  = out_roll_reg;
    assign pitch_deg = out_pitch_reg;
    assign switch_a  = out_sw_a_reg;
    assign switch_b  = out_sw_b_reg;
    assign switch_c  = out_sw_c_reg;
    assign aux_level = out_aux_reg;

    a_switch_codes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_sw_a_reg != sfd_pkg::SW_BAD
            && out_sw_b_reg != sfd_pkg::SW_BAD && out_sw_c_reg != sfd_pkg::SW_BAD)
        else $error("illegal switch code on output");

    a_held_only_on_frame: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_take |=> $stable(held_a_reg) && $stable(held_b_reg) && $stable(held_c_reg))
        else $error("held switch changed without a frame");

    a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && advance |=> out_valid_reg)
        else $error("stage 2 word lost");

endmodule

### src/sbus_frame_channel_decoder_unit.sv
`timescale 1ns / 1ps

// Radio-control serial frame decoder.
// Input channel (in_valid/in_ready): one received byte per word; frame_start
// marks the header byte, which restarts the byte count. Bytes 1..11 are
// collected; the word carrying byte 11 produces one output word. Other bytes
// (after byte 11, or with no header seen since reset) produce nothing.
// Output channel (out_valid/out_ready): throttle and aux_level raw, roll_deg
// and pitch_deg in signed degrees with 8 fraction bits, three switch
// positions (-1/0/+1; raw at or below the low threshold keeps the last one).
// Path: the edge accepting byte 11 loads the unpack register; the multiplier
// register and then the output register take the word after it, each moving
// only while the output register is empty or being taken.
// Throughput: one byte per cycle while the output side takes words; in_ready
// is high whenever the output register is empty or being taken.
// Receiver stall: the three stages freeze together and in_ready drops only
// once the output register is held and full.
// Reset: byte counter idle (waits for a header), held switches zero,
// thresholds 1200/800/100. Thresholds are written through cfg_we/cfg_addr/
// cfg_wdata, by the user only while no frame is in flight; not enforced here.
module sbus_frame_channel_decoder_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                frame_start,
    input  logic [7:0]                          rx_byte,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [sfd_pkg::CH_W-1:0]            throttle,
    output logic signed [sfd_pkg::ANGLE_W-1:0]  roll_deg,
    output logic signed [sfd_pkg::ANGLE_W-1:0]  pitch_deg,
    output logic signed [1:0]                   switch_a,
    output logic signed [1:0]                   switch_b,
    output logic signed [1:0]                   switch_c,
    output logic [sfd_pkg::CH_W-1:0]            aux_level,
    input  logic                                cfg_we,
    input  logic [sfd_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [sfd_pkg::CH_W-1:0]            cfg_wdata
);

    sfd_pkg::sfd_thresh_t thresh_reg;
    sfd_pkg::sfd_thresh_t thresh_next;
    sfd_pkg::sfd_chan_t   s1_chan;
    logic                 s1_valid;
    logic                 advance;
    logic                 accept;

    // Whole pipeline moves when the output register is empty or being taken
    assign advance  = !out_valid || out_ready;
    assign in_ready = advance;
    assign accept   = in_valid && advance;

    always_comb
    begin
        thresh_next = thresh_reg;
        if (cfg_we)
        begin
            case (cfg_addr)
                sfd_pkg::CFG_SW_HIGH: thresh_next.high = cfg_wdata;
                sfd_pkg::CFG_SW_MID:  thresh_next.mid  = cfg_wdata;
                sfd_pkg::CFG_SW_LOW:  thresh_next.low  = cfg_wdata;
                default:              thresh_next = thresh_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg.high <= sfd_pkg::SW_HIGH_RST;
            thresh_reg.mid  <= sfd_pkg::SW_MID_RST;
            thresh_reg.low  <= sfd_pkg::SW_LOW_RST;
        end
        else
        begin
            thresh_reg <= thresh_next;
        end
    end

    sfd_frame_asm u_asm (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .frame_start (frame_start),
        .rx_byte     (rx_byte),
        .advance     (advance),
        .s1_valid    (s1_valid),
        .s1_chan     (s1_chan)
    );

    sfd_chan_conv u_conv (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .s1_valid  (s1_valid),
        .s1_chan   (s1_chan),
        .thresh    (thresh_reg),
        .out_valid (out_valid),
        .throttle  (throttle),
        .roll_deg  (roll_deg),
        .pitch_deg (pitch_deg),
        .switch_a  (switch_a),
        .switch_b  (switch_b),
        .switch_c  (switch_c),
        .aux_level (aux_level)
    );

endmodule

### tb/sv/sfd_checker.sv
`timescale 1ns / 1ps

module sfd_frame_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic                                frame_start,
    input  logic [7:0]                          rx_byte,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic [sfd_pkg::CH_W-1:0]            throttle,
    input  logic signed [sfd_pkg::ANGLE_W-1:0]  roll_deg,
    input  logic signed [sfd_pkg::ANGLE_W-1:0]  pitch_deg,
    input  logic signed [1:0]                   switch_a,
    input  logic signed [1:0]                   switch_b,
    input  logic signed [1:0]                   switch_c,
    input  logic [sfd_pkg::CH_W-1:0]            aux_level,
    input  logic                                cfg_we,
    input  logic [sfd_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [sfd_pkg::CH_W-1:0]            cfg_wdata,
    output int                                  mismatch_count,
    output int                                  frames_outstanding
);

    import sfd_pkg::*;

    typedef struct {
        logic [CH_W-1:0]           throttle;
        logic signed [ANGLE_W-1:0] roll;
        logic signed [ANGLE_W-1:0] pitch;
        logic signed [1:0]         sw_a;
        logic signed [1:0]         sw_b;
        logic signed [1:0]         sw_c;
        logic [CH_W-1:0]           aux;
    } frame_result_t;

    // Gains in Q24
    localparam int     GAIN_FRAC     = 24;
    localparam int     DEG_SHIFT     = GAIN_FRAC - ANGLE_FRAC_BITS;
    localparam longint DEG45_Q24     = longint'(45) << GAIN_FRAC;
    localparam longint ROLL_HI_GAIN  = 924082;
    localparam longint ROLL_LO_GAIN  = 918462;
    localparam longint PITCH_LO_GAIN = 1003965;
    localparam longint PITCH_HI_GAIN = 851158;
    localparam longint KNEE_ROLL     = 994;
    localparam longint KNEE_PITCH    = 924;
    localparam longint RAW_FULL      = 1811;
    localparam longint RAW_BOTTOM    = 172;
    localparam longint DEG_MAX       = 16383;
    localparam longint DEG_MIN       = -16384;

    logic [3:0]        byte_pos;
    logic [7:0]        frame_bytes [1:11];
    logic signed [1:0] held_a;
    logic signed [1:0] held_b;
    logic signed [1:0] held_c;
    logic [CH_W-1:0]   thr_high;
    logic [CH_W-1:0]   thr_mid;
    logic [CH_W-1:0]   thr_low;
    frame_result_t     decoded_due [$];
    frame_result_t     want;

    // round half up, then clamp
    function automatic logic signed [ANGLE_W-1:0] q24_to_degrees(input longint q);
        longint v;
        v = (q + (longint'(1) <<< (DEG_SHIFT - 1))) >>> DEG_SHIFT;
        if (v > DEG_MAX)
            v = DEG_MAX;
        else if (v < DEG_MIN)
            v = DEG_MIN;
        return v[ANGLE_W-1:0];
    endfunction

    function automatic logic signed [ANGLE_W-1:0] roll_degrees(input logic [CH_W-1:0] raw);
        longint r;
        longint q;
        r = longint'(raw);
        if (r >= KNEE_ROLL)
            q = DEG45_Q24 - (RAW_FULL - r) * ROLL_HI_GAIN;
        else
            q = -DEG45_Q24 + (r - RAW_BOTTOM) * ROLL_LO_GAIN;
        return q24_to_degrees(q);
    endfunction

    function automatic logic signed [ANGLE_W-1:0] pitch_degrees(input logic [CH_W-1:0] raw);
        longint p;
        longint q;
        p = longint'(raw);
        if (p <= KNEE_PITCH)
            q = (p - KNEE_PITCH) * PITCH_LO_GAIN;
        else
            q = DEG45_Q24 - (RAW_FULL - p) * PITCH_HI_GAIN;
        return q24_to_degrees(q);
    endfunction

    // thresholds tested high, mid, low in that order regardless of values
    function automatic logic signed [1:0] switch_position(input logic [CH_W-1:0] raw,
                                                          input logic signed [1:0] held);
        if (raw > thr_high)
            return SW_POS;
        if (raw > thr_mid)
            return SW_ZERO;
        if (raw > thr_low)
            return SW_NEG;
        return held;
    endfunction

    task automatic decode_frame();
        logic [87:0]     bits;
        logic [CH_W-1:0] ch [1:8];
        frame_result_t   res;
        for (int i = 1; i <= 11; i++)
            bits[8*(i-1) +: 8] = frame_bytes[i];
        for (int k = 1; k <= 8; k++)
            ch[k] = bits[CH_W*(k-1) +: CH_W];
        held_a = switch_position(ch[5], held_a);
        held_b = switch_position(ch[6], held_b);
        held_c = switch_position(ch[8], held_c);
        res.throttle = ch[1];
        res.roll     = roll_degrees(ch[2]);
        res.pitch    = pitch_degrees(ch[3]);
        res.sw_a     = held_a;
        res.sw_b     = held_b;
        res.sw_c     = held_c;
        res.aux      = ch[7];
        decoded_due.push_back(res);
    endtask

    task automatic check_field(input string name, input logic signed [15:0] exp_val,
                               input logic signed [15:0] act_val);
        if (act_val !== exp_val)
        begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, exp_val, act_val);
            mismatch_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_pos = POS_IDLE;
            held_a   = SW_ZERO;
            held_b   = SW_ZERO;
            held_c   = SW_ZERO;
            thr_high = SW_HIGH_RST;
            thr_mid  = SW_MID_RST;
            thr_low  = SW_LOW_RST;
            decoded_due.delete();
            frames_outstanding = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (decoded_due.size() == 0)
                begin
                    $display("%0t: unexpected word: expected none, got throttle %0d",
                             $time, throttle);
                    mismatch_count++;
                end
                else
                begin
                    want = decoded_due.pop_front();
                    check_field("throttle",  want.throttle, throttle);
                    check_field("roll_deg",  want.roll,     roll_deg);
                    check_field("pitch_deg", want.pitch,    pitch_deg);
                    check_field("switch_a",  want.sw_a,     switch_a);
                    check_field("switch_b",  want.sw_b,     switch_b);
                    check_field("switch_c",  want.sw_c,     switch_c);
                    check_field("aux_level", want.aux,      aux_level);
                end
            end

            if (in_valid && in_ready)
            begin
                if (frame_start)
                    byte_pos = POS_FIRST;
                else if (byte_pos >= POS_FIRST && byte_pos <= POS_LAST)
                begin
                    frame_bytes[byte_pos] = rx_byte;
                    if (byte_pos == POS_LAST)
                        decode_frame();
                    byte_pos = byte_pos + 4'd1;
                end
            end

            if (cfg_we)
            begin
                case (cfg_addr)
                    CFG_SW_HIGH: thr_high = cfg_wdata;
                    CFG_SW_MID:  thr_mid  = cfg_wdata;
                    CFG_SW_LOW:  thr_low  = cfg_wdata;
                    default: ;
                endcase
            end

            frames_outstanding = decoded_due.size();
        end
    end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    import sfd_pkg::*;

    // Cycles without an input accept or output accept before the run is called dead.
    localparam int WATCHDOG_LIMIT  = 2000;
    // Cycles held after the last expected word before a threshold write or the verdict.
    localparam int DRAIN_CYCLES    = 8;
    localparam int NUM_PHASES      = 6;
    // Counted (non-ignored) bytes per random phase.
    localparam int BYTES_PER_PHASE = 90;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_ready;
    logic                       frame_start;
    logic [7:0]                 rx_byte;
    logic                       out_valid;
    logic                       out_ready;
    logic [CH_W-1:0]            throttle;
    logic signed [ANGLE_W-1:0]  roll_deg;
    logic signed [ANGLE_W-1:0]  pitch_deg;
    logic signed [1:0]          switch_a;
    logic signed [1:0]          switch_b;
    logic signed [1:0]          switch_c;
    logic [CH_W-1:0]            aux_level;
    logic                       cfg_we;
    logic [CFG_ADDR_W-1:0]      cfg_addr;
    logic [CH_W-1:0]            cfg_wdata;

    int                         mismatch_count;
    int                         frames_outstanding;
    int                         quiet_cycles = 0;

    // Stimulus-side view of the thresholds, used to aim channel values at them.
    logic [CH_W-1:0]            thr_high;
    logic [CH_W-1:0]            thr_mid;
    logic [CH_W-1:0]            thr_low;
    // When set, the sender puts words back to back.
    logic                       no_gaps;

    sbus_frame_channel_decoder_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .frame_start (frame_start),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .throttle    (throttle),
        .roll_deg    (roll_deg),
        .pitch_deg   (pitch_deg),
        .switch_a    (switch_a),
        .switch_b    (switch_b),
        .switch_c    (switch_c),
        .aux_level   (aux_level),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata)
    );

    sfd_frame_checker frame_check (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .frame_start        (frame_start),
        .rx_byte            (rx_byte),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .throttle           (throttle),
        .roll_deg           (roll_deg),
        .pitch_deg          (pitch_deg),
        .switch_a           (switch_a),
        .switch_b           (switch_b),
        .switch_c           (switch_c),
        .aux_level          (aux_level),
        .cfg_we             (cfg_we),
        .cfg_addr           (cfg_addr),
        .cfg_wdata          (cfg_wdata),
        .mismatch_count     (mismatch_count),
        .frames_outstanding (frames_outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Gap length shared by both sides: mostly short, now and then long.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // One word on the input channel. Valid goes up at a falling edge and stays
    // up with the payload held until the rising edge that sees in_ready.
    task automatic push_byte(input logic start, input logic [7:0] data);
        int gap;
        gap = 0;
        if (!no_gaps && $urandom_range(0, 99) >= 65)
            gap = gap_len();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        frame_start <= start;
        rx_byte     <= data;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Full frame: header plus 11 data bytes built from eight 11-bit channels.
    // Channel values lean toward the map knees, the raw extremes and the
    // current switch thresholds, where the decode logic branches.
    task automatic send_frame();
        logic [87:0] bits;
        int          pick;
        int          base;
        int          v;
        for (int k = 0; k < 8; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
                v = $urandom_range(0, 2047);
            else if (pick < 50)
            begin
                case ($urandom_range(0, 3))
                    0: v = 0;
                    1: v = 1;
                    2: v = 2046;
                    default: v = 2047;
                endcase
            end
            else if (pick < 92)
            begin
                case ($urandom_range(0, 6))
                    0: base = 172;
                    1: base = 924;
                    2: base = 994;
                    3: base = 1811;
                    4: base = thr_high;
                    5: base = thr_mid;
                    default: base = thr_low;
                endcase
                v = base + int'($urandom_range(0, 2)) - 1;
                if (v < 0)
                    v = 0;
                if (v > 2047)
                    v = 2047;
            end
            else
                v = $urandom_range(0, thr_low);    // at or below low: switch holds
            bits[CH_W*k +: CH_W] = CH_W'(v);
        end
        push_byte(1'b1, 8'($urandom));
        for (int i = 0; i < 11; i++)
            push_byte(1'b0, bits[8*i +: 8]);
    endtask

    // Let every expected word come out, then give the pipeline time to empty
    // before anything else touches the block.
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (frames_outstanding != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Output side: random stalls, with calm stretches where out_ready stays high.
    initial
    begin
        int   stall_left;
        int   mode_left;
        logic calm;
        out_ready  = 1'b0;
        stall_left = 0;
        mode_left  = 0;
        calm       = 1'b0;
        forever
        begin
            @(negedge clk);
            if (mode_left == 0)
            begin
                calm      = ($urandom_range(0, 3) == 0);
                mode_left = $urandom_range(50, 300);
            end
            mode_left--;
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready <= 1'b1;
                if (!calm && $urandom_range(0, 99) < 30)
                    stall_left = gap_len();
            end
        end
    end

    // Watchdog: cycles with no word moving on either channel.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        int sent;
        int chunk;
        int burst;
        in_valid     = 1'b0;
        frame_start  = 1'b0;
        rx_byte      = 8'h00;
        cfg_we       = 1'b0;
        cfg_addr     = CFG_SW_HIGH;
        cfg_wdata    = '0;
        no_gaps      = 1'b0;
        thr_high     = SW_HIGH_RST;
        thr_mid      = SW_MID_RST;
        thr_low      = SW_LOW_RST;
        rst_n        = 1'b0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, reset thresholds.
        // Bytes before any header are dropped.
        push_byte(1'b0, 8'hA5);
        push_byte(1'b0, 8'h5A);
        // All channels zero: both angles at their low end, switches hold zero.
        push_byte(1'b1, 8'h0F);
        repeat (11) push_byte(1'b0, 8'h00);
        // Header mid-frame restarts the count.
        push_byte(1'b1, 8'h0F);
        repeat (3) push_byte(1'b0, 8'hFF);
        // All channels full scale: angles at their top, switches go +1.
        push_byte(1'b1, 8'hFF);
        repeat (11) push_byte(1'b0, 8'hFF);
        // Bytes past byte 11 are dropped.
        push_byte(1'b0, 8'h00);
        push_byte(1'b0, 8'h3C);
        settle();

        // Random phases, each with its own threshold set.
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    thr_high = 11'd2047;
                    thr_mid  = 11'd2047;
                    thr_low  = 11'd2047;
                end
                1:
                begin
                    thr_high = 11'd0;
                    thr_mid  = 11'd0;
                    thr_low  = 11'd0;
                end
                2:
                begin
                    // inverted order: low above mid above high
                    thr_high = 11'd300;
                    thr_mid  = 11'd1000;
                    thr_low  = 11'd1500;
                end
                3:
                begin
                    thr_high = SW_HIGH_RST;
                    thr_mid  = SW_MID_RST;
                    thr_low  = SW_LOW_RST;
                end
                4:
                begin
                    thr_low  = CH_W'($urandom_range(0, 700));
                    thr_mid  = CH_W'($urandom_range(thr_low, 1400));
                    thr_high = CH_W'($urandom_range(thr_mid, 2047));
                end
                default:
                begin
                    thr_high = CH_W'($urandom_range(0, 2047));
                    thr_mid  = CH_W'($urandom_range(0, 2047));
                    thr_low  = CH_W'($urandom_range(0, 2047));
                end
            endcase

            @(negedge clk);
            cfg_we    <= 1'b1;
            cfg_addr  <= CFG_SW_HIGH;
            cfg_wdata <= thr_high;
            @(negedge clk);
            cfg_addr  <= CFG_SW_MID;
            cfg_wdata <= thr_mid;
            @(negedge clk);
            cfg_addr  <= CFG_SW_LOW;
            cfg_wdata <= thr_low;
            @(negedge clk);
            cfg_we    <= 1'b0;

            sent = 0;
            while (sent < BYTES_PER_PHASE)
            begin
                no_gaps = ($urandom_range(0, 4) == 0);
                chunk   = $urandom_range(0, 99);
                if (chunk < 78)
                begin
                    send_frame();
                    sent += 12;
                end
                else if (chunk < 88)
                begin
                    // cut-short frame; the next header throws it away
                    burst = $urandom_range(1, 10);
                    push_byte(1'b1, 8'($urandom));
                    repeat (burst) push_byte(1'b0, 8'($urandom));
                    sent += burst + 1;
                end
                else if (chunk < 94)
                begin
                    // stray bytes with no header
                    repeat ($urandom_range(1, 4)) push_byte(1'b0, 8'($urandom));
                end
                else
                begin
                    // line noise, an occasional header among it
                    repeat ($urandom_range(1, 6))
                        push_byte($urandom_range(0, 7) == 0, 8'($urandom));
                end
            end
            // close on a complete frame so the block is idle for the next writes
            no_gaps = 1'b0;
            send_frame();
            settle();
        end

        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### filelist.f
src/sfd_pkg.sv
src/sfd_frame_asm.sv
src/sfd_chan_conv.sv
src/sbus_frame_channel_decoder_unit.sv
tb/sv/sfd_checker.sv
tb/sv/tb_top.sv
